/* src/bee_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the byte escape encoder
package bee_pkg;

  localparam int unsigned SEQ_LEN = 4;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_X         = 8'h78;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [2:0] OCT_MASK     = 3'h7;
  localparam logic [3:0] HEX_MASK     = 4'hF;

  localparam logic [7:0] HEX_DIGITS [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  // one raw byte from the input channel
  typedef struct packed {
    logic [7:0] in_byte;
    logic       final_byte;
  } in_beat_t;

  // one escaped byte on the result channel
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;
  } out_beat_t;

  // escaped form of one raw byte: up to four bytes and index of the last one
  typedef struct packed {
    logic [SEQ_LEN-1:0][7:0] bytes;
    logic [1:0]              last_idx;
  } esc_seq_t;

endpackage

/* src/byte_escape_encoder.sv */
`timescale 1ns / 1ps
// top level of the byte escape encoder
// accepted beat -> run registers; each escaped byte -> result register
// throughput: one output byte per cycle while a run is active; a raw byte
// gives 1 to 4 escaped bytes; printable text flows at one byte per cycle
// busy holds start off until the final byte of the current run is issued
// synchronous active-low reset clears the run and the output strobe
module byte_escape_encoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  bee_pkg::in_beat_t   in_item,
  output logic                out_valid,
  output bee_pkg::out_beat_t  out_beat
);
  import bee_pkg::*;

  // escape sequence of the raw byte being offered
  esc_seq_t   enc_seq;

  // run registers: the sequence currently being issued
  esc_seq_t   run_seq_r,   run_seq_nxt;
  logic [1:0] run_idx_r,   run_idx_nxt;
  logic       run_fin_r,   run_fin_nxt;
  logic       run_act_r,   run_act_nxt;

  // result register
  out_beat_t  out_beat_r,  out_beat_nxt;
  logic       out_valid_r, out_valid_nxt;

  logic       accept;
  logic       run_on_last;

  bee_escape u_escape (
    .raw (in_item.in_byte),
    .seq (enc_seq)
  );

  // the last byte of a run frees the run registers for the next start
  assign run_on_last = run_act_r && (run_idx_r == run_seq_r.last_idx);
  assign busy        = run_act_r && !run_on_last;
  assign accept      = start && !busy;

  always_comb begin
    run_seq_nxt = run_seq_r;
    run_idx_nxt = run_idx_r;
    run_fin_nxt = run_fin_r;
    run_act_nxt = run_act_r;
    if (accept) begin
      run_seq_nxt = enc_seq;
      run_idx_nxt = 2'd0;
      run_fin_nxt = in_item.final_byte;
      run_act_nxt = 1'b1;
    end else if (run_on_last) begin
      run_act_nxt = 1'b0;
    end else if (run_act_r) begin
      run_idx_nxt = run_idx_r + 2'd1;
    end
  end

  // pick the current byte of the run and tag the end of run / string
  always_comb begin
    out_valid_nxt           = run_act_r;
    out_beat_nxt.out_byte   = run_seq_r.bytes[run_idx_r];
    out_beat_nxt.run_last   = run_on_last;
    out_beat_nxt.string_end = run_on_last && run_fin_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_act_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      run_act_r   <= run_act_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers carry no reset
  always_ff @(posedge clk) begin
    run_seq_r  <= run_seq_nxt;
    run_idx_r  <= run_idx_nxt;
    run_fin_r  <= run_fin_nxt;
    out_beat_r <= out_beat_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  // every accepted beat shows its first escaped byte on the output strobe
  a_start_to_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##2 out_valid)
    else $error("accepted beat did not reach the output");

  // a run is never cut short
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_beat.run_last) |=> out_valid)
    else $error("escape run broken before its last byte");

  // end of string only on the closing byte of a run
  a_end_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_beat.string_end) |-> out_beat.run_last)
    else $error("string end flagged mid-run");

  // the run index stays within the sequence
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    run_act_r |-> (run_idx_r <= run_seq_r.last_idx))
    else $error("run index past end of sequence");

endmodule

/* src/bee_escape.sv */
`timescale 1ns / 1ps
// combinational escape table: raw byte to escape sequence
module bee_escape (
  input  logic [7:0]        raw,
  output bee_pkg::esc_seq_t seq
);
  import bee_pkg::*;

  logic [7:0] named;

  always_comb begin
    case (raw)
      8'h07:   named = 8'h61; // a
      8'h08:   named = 8'h62; // b
      8'h0C:   named = 8'h66; // f
      8'h0A:   named = 8'h6E; // n
      8'h0D:   named = 8'h72; // r
      8'h09:   named = 8'h74; // t
      8'h27:   named = 8'h27;
      8'h22:   named = 8'h22;
      8'h5C:   named = 8'h5C;
      default: named = 8'h00;
    endcase
  end

  always_comb begin
    seq.bytes    = '0;
    seq.last_idx = 2'd0;
    if (named != 8'h00) begin
      seq.bytes[0] = CH_BACKSLASH;
      seq.bytes[1] = named;
      seq.last_idx = 2'd1;
    end else if (raw >= 8'h20 && raw <= 8'h7E) begin
      seq.bytes[0] = raw;
    end else if (raw < 8'h08) begin
      seq.bytes[0] = CH_BACKSLASH;
      seq.bytes[1] = CH_ZERO + {5'd0, raw[2:0]};
      seq.last_idx = 2'd1;
    end else if (raw < 8'h40) begin
      seq.bytes[0] = CH_BACKSLASH;
      seq.bytes[1] = CH_ZERO + {5'd0, raw[5:3] & OCT_MASK};
      seq.bytes[2] = CH_ZERO + {5'd0, raw[2:0] & OCT_MASK};
      seq.last_idx = 2'd2;
    end else begin
      seq.bytes[0] = CH_BACKSLASH;
      seq.bytes[1] = CH_X;
      seq.bytes[2] = HEX_DIGITS[raw[7:4] & HEX_MASK];
      seq.bytes[3] = HEX_DIGITS[raw[3:0] & HEX_MASK];
      seq.last_idx = 2'd3;
    end
  end

endmodule
